// ----- hdl/tes_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tes_pkg: shared types and constants of the terminal escape stripper
// Holds the transfer structs, buffer geometry, character codes and parser
// phase codes.
// ----------------------------------------------------------------------------
package tes_pkg;

    // text buffer geometry (valid range 4 .. 64)
    localparam int BUF_DEPTH = 64;
    localparam int ADDR_W    = $clog2(BUF_DEPTH);

    // character codes
    localparam logic [7:0] CH_ESC    = 8'h1b;
    localparam logic [7:0] CH_CR     = 8'h0d;
    localparam logic [7:0] CH_LF     = 8'h0a;
    localparam logic [7:0] CH_BS     = 8'h08;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_LBRACK = 8'h5b;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_QMARK  = 8'h3f;
    localparam logic [7:0] CH_SEMI   = 8'h3b;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;

    // escape parser phases
    localparam logic [2:0] PH_IDLE     = 3'd0;
    localparam logic [2:0] PH_INIT     = 3'd1;
    localparam logic [2:0] PH_BRACKET  = 3'd2;
    localparam logic [2:0] PH_HASH     = 3'd3;
    localparam logic [2:0] PH_NUMBER   = 3'd4;
    localparam logic [2:0] PH_QUESTION = 3'd5;
    localparam logic [2:0] PH_PAREN    = 3'd6;
    localparam logic [2:0] PH_EAT1     = 3'd7;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_stream;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_of_run;
    } t_out_item;

endpackage : tes_pkg
`default_nettype wire

// ----- hdl/tes_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tes_ram: generic simple dual-port ram
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module tes_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule : tes_ram
`default_nettype wire

// ----- hdl/terminal_escape_stripper.sv -----
`timescale 1ns / 1ps
`default_nettype none
// flow: a transfer that triggers a flush moves the sequencer through ST_RD and then
//   ST_LOAD before the first byte of the run is registered at the output
// throughput: one input byte per cycle outside flushes; during a run the input stays
//   stalled, each byte going through the read-then-load sequence on the buffer ram
// reset: synchronous, active low; parser idle, buffer empty, no output pending.
//   buffer ram contents are not cleared, only entries below the fill count are read
// ----------------------------------------------------------------------------
// terminal_escape_stripper: removes terminal escape sequences from a byte stream
// Bytes outside escapes are collected in a ram buffer and emitted as runs,
// either when the buffer fills or at end of stream.
// ----------------------------------------------------------------------------
module terminal_escape_stripper (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // input channel
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire tes_pkg::t_in_item  i_in_item,
    // output channel
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output tes_pkg::t_out_item      o_out_item
);

    import tes_pkg::*;

    // flush sequencer states
    localparam logic [1:0] ST_IDLE = 2'd0;  // taking input bytes
    localparam logic [1:0] ST_RD   = 2'd1;  // buffer read issued
    localparam logic [1:0] ST_LOAD = 2'd2;  // read data waits for the output register

    localparam logic [ADDR_W-1:0] FULL_FILL = ADDR_W'(BUF_DEPTH - 1);

    logic [1:0]        r_state,   n_state;
    logic [2:0]        r_phase,   n_phase;
    logic [ADDR_W-1:0] r_fill,    n_fill;
    logic [ADDR_W-1:0] r_idx,     n_idx;       // read pointer during a flush
    logic [ADDR_W-1:0] r_run_end, n_run_end;   // index of the last byte of the run
    logic              r_out_valid, n_out_valid;
    t_out_item         r_out_item,  n_out_item;

    logic              in_xfer;
    logic              out_free;
    logic              load_out;
    logic              ram_we;
    logic [7:0]        ram_rdata;
    logic [7:0]        c;
    logic              is_digit;

    // escape parser step; PH_IDLE means the sequence ended on this byte
    function automatic logic [2:0] escape_next(input logic [2:0] ph,
                                               input logic [7:0] ch,
                                               input logic       dig);
        logic [2:0] nx;
        nx = PH_IDLE;
        unique case (ph)
            PH_INIT: begin
                if (ch == CH_LBRACK) nx = PH_BRACKET;
                else if (ch == CH_HASH) nx = PH_HASH;
            end
            PH_BRACKET: begin
                if (dig) nx = PH_NUMBER;
                else if (ch == CH_QMARK) nx = PH_QUESTION;
                else if (ch == CH_LPAREN || ch == CH_RPAREN) nx = PH_PAREN;
            end
            PH_QUESTION: begin
                nx = dig ? PH_NUMBER : PH_EAT1;
            end
            PH_NUMBER: begin
                if (dig || ch == CH_SEMI) nx = PH_NUMBER;
            end
            default: begin
                nx = PH_IDLE;   // hash, paren and eat-one end on any byte
            end
        endcase
        return nx;
    endfunction

    assign c          = i_in_item.in_byte;
    assign is_digit   = (c >= CH_ZERO) && (c <= CH_NINE);
    assign o_in_stall = (r_state != ST_IDLE);
    assign in_xfer    = i_in_valid && !o_in_stall;
    // output register can take a new byte this cycle
    assign out_free   = !r_out_valid || !i_out_stall;
    assign load_out   = (r_state == ST_LOAD) && out_free;

    always_comb begin
        n_state     = r_state;
        n_phase     = r_phase;
        n_fill      = r_fill;
        n_idx       = r_idx;
        n_run_end   = r_run_end;
        n_out_valid = r_out_valid;
        n_out_item  = r_out_item;
        ram_we      = 1'b0;

        // output register drains on a transfer
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (in_xfer) begin
                    if (i_in_item.end_of_stream) begin
                        // drain whatever is buffered, abandon any open escape
                        n_phase = PH_IDLE;
                        if (r_fill != '0) begin
                            n_run_end = r_fill - 1'b1;
                            n_idx     = '0;
                            n_fill    = '0;
                            n_state   = ST_RD;
                        end
                    end else if (r_phase != PH_IDLE) begin
                        n_phase = escape_next(r_phase, c, is_digit);
                    end else if (c == CH_ESC) begin
                        n_phase = PH_INIT;
                    end else if (c == CH_CR) begin
                        n_phase = PH_IDLE;  // dropped
                    end else if (c == CH_BS) begin
                        if (r_fill != '0) n_fill = r_fill - 1'b1;
                    end else begin
                        // store, line feeds included; full buffer flushes at once
                        ram_we = 1'b1;
                        if (r_fill == FULL_FILL - 1'b1) begin
                            n_run_end = FULL_FILL - 1'b1;
                            n_idx     = '0;
                            n_fill    = '0;
                            n_state   = ST_RD;
                        end else begin
                            n_fill = r_fill + 1'b1;
                        end
                    end
                end
            end
            ST_RD: begin
                n_state = ST_LOAD;
            end
            ST_LOAD: begin
                if (out_free) begin
                    n_out_valid            = 1'b1;
                    n_out_item.out_byte    = ram_rdata;
                    n_out_item.last_of_run = (r_idx == r_run_end);
                    n_idx                  = r_idx + 1'b1;
                    n_state                = (r_idx == r_run_end) ? ST_IDLE : ST_RD;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_phase     <= PH_IDLE;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_fill      <= n_fill;
            r_out_valid <= n_out_valid;
        end
    end

    // payload and flush pointers need no reset
    always_ff @(posedge i_clk) begin
        r_idx      <= n_idx;
        r_run_end  <= n_run_end;
        r_out_item <= n_out_item;
    end

    // text buffer: written at the fill count, read at the flush pointer
    tes_ram #(
        .WIDTH (8),
        .DEPTH (BUF_DEPTH)
    ) u_buf (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_fill),
        .i_wdata (c),
        .i_raddr (r_idx),
        .o_rdata (ram_rdata)
    );

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // fill count never reaches BUF_DEPTH-1: the store that would bring it there starts a flush
    a_fill_below_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill != FULL_FILL)
        else $error("fill count reached the full mark");

    // a run is always drained from an emptied buffer
    a_flush_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != ST_IDLE |-> r_fill == '0)
        else $error("fill count nonzero during a flush");

    // read pointer never passes the end of the run
    a_idx_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != ST_IDLE |-> r_idx <= r_run_end)
        else $error("flush pointer beyond run end");

    // loading the last byte of a run frees the input side
    a_last_ends_flush: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load_out && (r_idx == r_run_end) |=> r_state == ST_IDLE && o_out_item.last_of_run)
        else $error("run end did not return to idle");

endmodule : terminal_escape_stripper
`default_nettype wire
